@@ design/wmd_pkg.sv @@
// ----------------------------------------------------------------------------
// wmd_pkg: shared types and constants of the min/max waveform decimator
// Holds the controller states, the divider operand select, the register
// indexes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wmd_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int DVSR_W         = 16;
  localparam int ZOOM_UNITY     = 256;
  localparam int SCROLL_UNITY   = 65536;
  localparam int PADDR_W        = 4;
  localparam int STRIDE_DIVISOR = 256;
  localparam int STRIDE_SHIFT   = $clog2(STRIDE_DIVISOR);

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_VLEN, ST_VST, ST_DIV_SPP, ST_PROD, ST_SPAN,
    ST_SCAN, ST_INT0, ST_INT1, ST_INT2, ST_INT3, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DSEL_VLEN, DSEL_SPP
  } div_sel_t;

  typedef enum logic [1:0] {
    REG_FRAME_COUNT, REG_ZOOM, REG_SCROLL, REG_WIDTH
  } reg_idx_t;

  typedef struct packed {
    logic     write;
    logic     take;
    logic     div_start;
    div_sel_t div_sel;
    logic     vlen_en;
    logic     vst_en;
    logic     spp_en;
    logic     prod_en;
    logic     span_en;
    logic     stride_en;
    logic     scan_issue;
    logic     rd_ip;
    logic     rd_ip1;
    logic     s0_en;
    logic     mul_en;
    logic     int_en;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic div_done;
    logic span_scan;
    logic scan_more;
  } status_t;

endpackage

@@ design/waveform_minmax_decimator.sv @@
// ----------------------------------------------------------------------------
// waveform_minmax_decimator: min/max peak decimation for a waveform display
// Stereo sample store with per-column peak extraction over a zoomed and
// scrolled window, set up through a small register port.
// ----------------------------------------------------------------------------
// Usage. A request is taken on a rising edge with start high and busy low.
// With mode at load, the pair left_sample/right_sample is written to the store
// at frame_address in that same edge; busy stays low and the next request can
// follow at once. With mode at render, busy rises and the block works out the
// column span of pixel_index from frame_count, zoom_factor, scroll_position
// and display_width. It then scans that span with a stride of
// max(1, span/STRIDE_DIVISOR) reading one stored frame per cycle, or, for a
// column narrower than a frame, interpolates between two frames. The result
// appears for exactly one cycle with result_valid high and busy drops after.
// A render runs two divisions in the shared serial divider with the setup
// states ST_VST, ST_PROD and ST_SPAN, then either the scan of the span (at
// most 511 frames) or the interpolation states ST_INT0 to ST_INT3. An empty
// render (no frames, zero width, or a column beyond the width) shows its
// result in the cycle after the request. A new request can be taken in the
// cycle after the result.
// The receiver cannot stall the result. Reset returns the controller to idle
// and the registers to their defaults; the store is not cleared.
// ----------------------------------------------------------------------------
module waveform_minmax_decimator #(
  parameter int MAX_FRAMES     = 65536,
  parameter int MAX_WIDTH      = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wmd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Request side.
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [15:0]                   frame_address,
  input  logic signed [15:0]            left_sample,
  input  logic signed [15:0]            right_sample,
  input  logic [11:0]                   pixel_index,
  // Result side.
  output logic                          result_valid,
  output logic [11:0]                   pixel_out,
  output logic signed [15:0]            peak_max,
  output logic signed [15:0]            peak_min,
  output logic                          empty_flag
);

  // Configuration registers.
  logic [16:0] frame_count;
  logic [15:0] zoom_factor;
  logic [16:0] scroll_position;
  logic [12:0] display_width;

  wmd_pkg::reg_idx_t reg_idx;
  logic              reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = wmd_pkg::reg_idx_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count     <= '0;
      zoom_factor     <= 16'(wmd_pkg::ZOOM_UNITY);
      scroll_position <= '0;
      display_width   <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        wmd_pkg::REG_FRAME_COUNT: frame_count     <= pwdata[16:0];
        wmd_pkg::REG_ZOOM:        zoom_factor     <= pwdata[15:0];
        wmd_pkg::REG_SCROLL:      scroll_position <= pwdata[16:0];
        wmd_pkg::REG_WIDTH:       display_width   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wmd_pkg::REG_FRAME_COUNT: prdata = 32'(frame_count);
      wmd_pkg::REG_ZOOM:        prdata = 32'(zoom_factor);
      wmd_pkg::REG_SCROLL:      prdata = 32'(scroll_position);
      wmd_pkg::REG_WIDTH:       prdata = 32'(display_width);
      default:                  prdata = '0;
    endcase
  end

  // The controller sequences; the datapath holds the store and arithmetic.
  wmd_pkg::cmd_t    cmd;
  wmd_pkg::status_t status;

  wmd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  wmd_dp #(
    .MAX_FRAMES     (MAX_FRAMES),
    .MAX_WIDTH      (MAX_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .frame_count     (frame_count),
    .zoom_factor     (zoom_factor),
    .scroll_position (scroll_position),
    .display_width   (display_width),
    .frame_address   (frame_address),
    .left_sample     (left_sample),
    .right_sample    (right_sample),
    .pixel_index     (pixel_index),
    .pixel_out       (pixel_out),
    .peak_max        (peak_max),
    .peak_min        (peak_min),
    .empty_flag      (empty_flag)
  );

  // A result lasts exactly one cycle.
  assert property (@(posedge clk) disable iff (rst) result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

  // Load requests never make the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == wmd_pkg::MODE_LOAD) |=> !busy)
    else $error("load request raised busy");

  // A result is only shown while a render is in flight.
  assert property (@(posedge clk) disable iff (rst) result_valid |-> busy)
    else $error("result strobe outside a render");

  // Empty results carry zero peaks.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && empty_flag) |-> (peak_max == 16'sd0 && peak_min == 16'sd0))
    else $error("empty result with nonzero peaks");

  // The maximum never falls below the minimum.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !empty_flag) |-> (peak_max >= peak_min))
    else $error("peak maximum below peak minimum");

endmodule

@@ design/wmd_div.sv @@
// ----------------------------------------------------------------------------
// wmd_div: restoring divider, one quotient bit per cycle
// Unsigned dividend of DVW bits by a 16-bit nonzero divisor.
// ----------------------------------------------------------------------------
module wmd_div #(
  parameter int DVW = 33
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DVW-1:0]                dividend,
  input  logic [wmd_pkg::DVSR_W-1:0]    divisor,
  output logic                          done,
  output logic [DVW-1:0]                quotient
);

  localparam int CW = $clog2(DVW + 1);

  logic                       busy;
  logic                       done_r;
  logic [CW-1:0]              cnt;
  logic [wmd_pkg::DVSR_W-1:0] rem;
  logic [wmd_pkg::DVSR_W-1:0] dvs;
  logic [DVW-1:0]             quo;
  logic [wmd_pkg::DVSR_W:0]   rem_sh;
  logic [wmd_pkg::DVSR_W:0]   rem_sub;
  logic                       ge;

  always_comb begin
    rem_sh  = {rem, quo[DVW-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = ge ? rem_sh - {1'b0, dvs} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DVW - 1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_sub[wmd_pkg::DVSR_W-1:0];
      quo <= {quo[DVW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo;

endmodule

@@ design/wmd_ctrl.sv @@
// ----------------------------------------------------------------------------
// wmd_ctrl: sequencing state machine of the decimator
// Takes load requests in idle and steps a render request through window setup, span scan or interpolation.
// ----------------------------------------------------------------------------
module wmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              mode,
  input  wmd_pkg::status_t  status,
  output wmd_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              result_valid
);

  wmd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wmd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.div_sel  = wmd_pkg::DSEL_VLEN;
    busy         = 1'b1;
    result_valid = 1'b0;
    unique case (state)
      wmd_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start && mode == wmd_pkg::MODE_LOAD) begin
          cmd.write = 1'b1;
        end else if (start && mode == wmd_pkg::MODE_RENDER) begin
          cmd.take = 1'b1;
          if (status.empty) begin
            state_next = wmd_pkg::ST_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = wmd_pkg::ST_DIV_VLEN;
          end
        end
      end
      wmd_pkg::ST_DIV_VLEN: begin
        if (status.div_done) begin
          cmd.vlen_en = 1'b1;
          state_next  = wmd_pkg::ST_VST;
        end
      end
      wmd_pkg::ST_VST: begin
        cmd.vst_en    = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = wmd_pkg::DSEL_SPP;
        state_next    = wmd_pkg::ST_DIV_SPP;
      end
      wmd_pkg::ST_DIV_SPP: begin
        if (status.div_done) begin
          cmd.spp_en = 1'b1;
          state_next = wmd_pkg::ST_PROD;
        end
      end
      wmd_pkg::ST_PROD: begin
        cmd.prod_en = 1'b1;
        state_next  = wmd_pkg::ST_SPAN;
      end
      wmd_pkg::ST_SPAN: begin
        cmd.span_en = 1'b1;
        if (status.span_scan) begin
          cmd.stride_en = 1'b1;
          state_next    = wmd_pkg::ST_SCAN;
        end else begin
          state_next = wmd_pkg::ST_INT0;
        end
      end
      wmd_pkg::ST_SCAN: begin
        if (status.scan_more) begin
          cmd.scan_issue = 1'b1;
        end else begin
          state_next = wmd_pkg::ST_DONE;
        end
      end
      wmd_pkg::ST_INT0: begin
        cmd.rd_ip  = 1'b1;
        state_next = wmd_pkg::ST_INT1;
      end
      wmd_pkg::ST_INT1: begin
        cmd.rd_ip1 = 1'b1;
        cmd.s0_en  = 1'b1;
        state_next = wmd_pkg::ST_INT2;
      end
      wmd_pkg::ST_INT2: begin
        cmd.mul_en = 1'b1;
        state_next = wmd_pkg::ST_INT3;
      end
      wmd_pkg::ST_INT3: begin
        cmd.int_en = 1'b1;
        state_next = wmd_pkg::ST_DONE;
      end
      wmd_pkg::ST_DONE: begin
        result_valid = 1'b1;
        state_next   = wmd_pkg::ST_IDLE;
      end
      default: begin
        state_next = wmd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/wmd_dp.sv @@
// ----------------------------------------------------------------------------
// wmd_dp: datapath of the decimator
// Sample store, window arithmetic, shared divider, span scan and
// interpolation, and the result registers.
// ----------------------------------------------------------------------------
module wmd_dp #(
  parameter int MAX_FRAMES     = 65536,
  parameter int MAX_WIDTH      = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  wmd_pkg::cmd_t       cmd,
  output wmd_pkg::status_t    status,
  input  logic [16:0]         frame_count,
  input  logic [15:0]         zoom_factor,
  input  logic [16:0]         scroll_position,
  input  logic [12:0]         display_width,
  input  logic [15:0]         frame_address,
  input  logic signed [15:0]  left_sample,
  input  logic signed [15:0]  right_sample,
  input  logic [11:0]         pixel_index,
  output logic [11:0]         pixel_out,
  output logic signed [15:0]  peak_max,
  output logic signed [15:0]  peak_min,
  output logic                empty_flag
);

  localparam int NW  = $clog2(MAX_FRAMES + 1);
  localparam int AW  = $clog2(MAX_FRAMES);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int SW  = NW + wmd_pkg::FRAC_BITS;
  localparam int PW  = SW + 13;
  localparam int EW  = NW + 14;
  localparam int MVW = NW + 17;

  // Clamped register views.
  logic [NW-1:0] n_c;
  logic [15:0]   z_c;
  logic [16:0]   s_c;
  logic [WW-1:0] w_c;
  logic          empty_c;

  always_comb begin
    n_c = (32'(frame_count) > 32'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : NW'(frame_count);
    z_c = (zoom_factor < 16'(wmd_pkg::ZOOM_UNITY)) ? 16'(wmd_pkg::ZOOM_UNITY)
                                                   : zoom_factor;
    s_c = (scroll_position > 17'(wmd_pkg::SCROLL_UNITY)) ? 17'(wmd_pkg::SCROLL_UNITY)
                                                        : scroll_position;
    w_c = (32'(display_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(display_width);
    empty_c = (n_c == '0) || (w_c == '0) || (32'(pixel_index) >= 32'(w_c));
  end

  logic [11:0]        px_q;
  logic               empty_q;
  logic [NW-1:0]      vlen_q;
  logic [NW-1:0]      vst_q;
  logic [SW-1:0]      spp_q;
  logic [PW-1:0]      p0_q;
  logic [PW-1:0]      p1_q;
  logic [NW-1:0]      en_q;
  logic [NW-1:0]      ip_q;
  logic [15:0]        f_q;
  logic [NW-1:0]      stride_q;
  logic [NW:0]        addr_q;
  logic               rd_vld_q;
  logic               first_q;
  logic [31:0]        mem_q;
  logic signed [16:0] s0_q;
  logic signed [34:0] prod_q;
  logic signed [15:0] max_q;
  logic signed [15:0] min_q;

  // Shared divider.
  logic [SW-1:0]              dvd_c;
  logic [wmd_pkg::DVSR_W-1:0] dvs_c;
  logic                       div_done;
  logic [SW-1:0]              quo;

  // Span arithmetic.
  logic [MVW-1:0]     mul_v;
  logic [EW-1:0]      st_w;
  logic [EW-1:0]      en_w;
  logic [NW-1:0]      en_c;
  logic [NW-1:0]      st_c;
  logic [NW-1:0]      n2_c;
  logic [NW-1:0]      ip_c;
  logic [NW-1:0]      span_c;
  logic [NW-1:0]      stride_c;
  logic [NW-1:0]      rd_full;
  logic signed [16:0] sum_c;
  logic signed [15:0] m_c;
  logic signed [17:0] diff_c;
  logic signed [35:0] acc_c;

  always_comb begin
    mul_v = MVW'(s_c) * MVW'(n_c - vlen_q);
    st_w  = EW'(vst_q) + EW'(p0_q >> wmd_pkg::FRAC_BITS);
    en_w  = EW'(vst_q) + EW'(p1_q >> wmd_pkg::FRAC_BITS);
    en_c  = (en_w > EW'(n_c)) ? n_c : NW'(en_w);
    st_c  = NW'(st_w);
    n2_c  = n_c - NW'(2);
    if (n_c == NW'(1)) begin
      ip_c = '0;
    end else if (st_w > EW'(n2_c)) begin
      ip_c = n2_c;
    end else begin
      ip_c = st_c;
    end
    // The stride divisor is a power of two, so the stride is a shift.
    span_c   = en_c - st_c;
    stride_c = ((span_c >> wmd_pkg::STRIDE_SHIFT) == '0) ? NW'(1)
                                                         : (span_c >> wmd_pkg::STRIDE_SHIFT);
  end

  always_comb begin
    unique case (cmd.div_sel)
      wmd_pkg::DSEL_VLEN: begin
        dvd_c = SW'({n_c, 8'b0});
        dvs_c = z_c;
      end
      wmd_pkg::DSEL_SPP: begin
        dvd_c = SW'({vlen_q, 16'b0});
        dvs_c = wmd_pkg::DVSR_W'(w_c);
      end
      default: begin
        dvd_c = '0;
        dvs_c = wmd_pkg::DVSR_W'(1);
      end
    endcase
  end

  wmd_div #(.DVW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd_c),
    .divisor  (dvs_c),
    .done     (div_done),
    .quotient (quo)
  );

  // Sample store: left in the upper half, right in the lower half.
  logic [31:0]   mem [MAX_FRAMES];
  logic [AW-1:0] rd_addr;

  always_comb begin
    if (cmd.rd_ip1) begin
      rd_full = ip_q + NW'(1);
    end else if (cmd.rd_ip) begin
      rd_full = ip_q;
    end else begin
      rd_full = addr_q[NW-1:0];
    end
    rd_addr = rd_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.write && (32'(frame_address) < 32'(MAX_FRAMES))) begin
      mem[AW'(frame_address)] <= {left_sample, right_sample};
    end
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    sum_c  = $signed({mem_q[31], mem_q[31:16]}) + $signed({mem_q[15], mem_q[15:0]});
    m_c    = sum_c[16:1];
    diff_c = (n_c == NW'(1)) ? 18'sd0 : ({sum_c[16], sum_c} - {s0_q[16], s0_q});
    acc_c  = (36'(s0_q) <<< wmd_pkg::FRAC_BITS) + 36'(prod_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px_q    <= pixel_index;
      empty_q <= empty_c;
      if (empty_c) begin
        max_q <= '0;
        min_q <= '0;
      end
    end
    if (cmd.vlen_en) vlen_q <= NW'(quo);
    if (cmd.vst_en) vst_q <= NW'(mul_v >> wmd_pkg::FRAC_BITS);
    if (cmd.spp_en) spp_q <= quo;
    if (cmd.prod_en) begin
      p0_q <= PW'(px_q) * PW'(spp_q);
      p1_q <= PW'(13'(px_q) + 13'd1) * PW'(spp_q);
    end
    if (cmd.span_en) begin
      addr_q  <= (NW + 1)'(st_c);
      en_q    <= en_c;
      ip_q    <= ip_c;
      f_q     <= p0_q[15:0];
      first_q <= 1'b1;
    end
    if (cmd.stride_en) begin
      stride_q <= stride_c;
    end
    if (cmd.scan_issue) begin
      addr_q <= addr_q + (NW + 1)'(stride_q);
    end
    if (rd_vld_q) begin
      first_q <= 1'b0;
      if (first_q) begin
        max_q <= m_c;
        min_q <= m_c;
      end else begin
        if (m_c > max_q) max_q <= m_c;
        if (m_c < min_q) min_q <= m_c;
      end
    end
    if (cmd.s0_en) s0_q <= sum_c;
    if (cmd.mul_en) prod_q <= diff_c * $signed({1'b0, f_q});
    if (cmd.int_en) begin
      max_q <= acc_c[32:17];
      min_q <= acc_c[32:17];
    end
  end

  always_comb begin
    status.empty     = empty_c;
    status.div_done  = div_done;
    status.span_scan = st_w < EW'(en_c);
    status.scan_more = addr_q < {1'b0, en_q};
  end

  assign pixel_out  = px_q;
  assign peak_max   = max_q;
  assign peak_min   = min_q;
  assign empty_flag = empty_q;

endmodule

@@ tb/waveform_minmax_decimator_test.sv @@
// ----------------------------------------------------------------------------
// waveform_minmax_decimator_test: self-checking bench of the peak decimator
// Loads the store entries that each render reads, then runs directed and
// random register settings with mixed load and render requests, predicts
// every column result in the bench and compares each strobed result.
// ----------------------------------------------------------------------------
module waveform_minmax_decimator_test;

  localparam int STORE_DEPTH = 65536;
  localparam int WIDTH_CAP   = 4096;
  localparam int STRIDE_DIV  = 256;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE      = 200;

  // One request as the bench sees it.
  typedef struct {
    logic                 mode;
    logic [15:0]          addr;
    logic signed [15:0]   left;
    logic signed [15:0]   right;
    logic [11:0]          pixel;
  } req_t;

  // One column result.
  typedef struct {
    logic [11:0]          pixel;
    logic signed [15:0]   pmax;
    logic signed [15:0]   pmin;
    logic                 empty;
  } peak_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [wmd_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic mode = wmd_pkg::MODE_LOAD;
  logic [15:0] frame_address = '0;
  logic signed [15:0] left_sample = '0, right_sample = '0;
  logic [11:0] pixel_index = '0;
  logic result_valid;
  logic [11:0] pixel_out;
  logic signed [15:0] peak_max, peak_min;
  logic empty_flag;

  // Bench copy of the store and the registers.
  logic signed [15:0] left_mem  [STORE_DEPTH];
  logic signed [15:0] right_mem [STORE_DEPTH];
  bit                 written   [STORE_DEPTH];
  int unsigned cfg_frames = 0, cfg_zoom = 256, cfg_scroll = 0, cfg_width = 0;

  req_t  pending_reqs[$];
  req_t  cur_req;
  peak_t expected_peaks[$];
  int    errors = 0;
  int    idle_pct = 7;
  int    cycles = 0;

  waveform_minmax_decimator u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .mode, .frame_address, .left_sample, .right_sample,
    .pixel_index, .result_valid, .pixel_out, .peak_max, .peak_min, .empty_flag
  );

  always #1 clk = ~clk;

  // The run is cut off if it hangs anywhere.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Works out the column result of a render from the bench state, with all
  // fixed-point steps done in 64-bit integers.
  function automatic peak_t column_peak(logic [11:0] px);
    peak_t r;
    longint n, z, s, w, p, vlen, vst, spp, st, en, pos, ip, f, acc, step, v;
    longint vmax, vmin;
    n = cfg_frames > STORE_DEPTH ? STORE_DEPTH : cfg_frames;
    z = cfg_zoom < 256 ? 256 : cfg_zoom;
    s = cfg_scroll > 65536 ? 65536 : cfg_scroll;
    w = cfg_width > WIDTH_CAP ? WIDTH_CAP : cfg_width;
    p = px;
    r.pixel = px;
    r.pmax = '0;
    r.pmin = '0;
    r.empty = 1'b1;
    if (n == 0 || w == 0 || p >= w) return r;
    r.empty = 1'b0;
    vlen = (n * 256) / z;
    vst = (s * (n - vlen)) >> 16;
    spp = (vlen << 16) / w;
    st = vst + ((p * spp) >> 16);
    en = vst + (((p + 1) * spp) >> 16);
    if (en > n) en = n;
    if (st >= en) begin
      // Column narrower than one frame: interpolate at its start position.
      pos = (vst << 16) + p * spp;
      ip = pos >> 16;
      f = pos & 64'hFFFF;
      if (n == 1) begin
        vmax = (longint'(left_mem[0]) + longint'(right_mem[0])) >>> 1;
      end else begin
        if (ip > n - 2) ip = n - 2;
        acc = (longint'(left_mem[ip]) + longint'(right_mem[ip])) * 65536
            + (longint'(left_mem[ip+1]) + longint'(right_mem[ip+1])
               - longint'(left_mem[ip]) - longint'(right_mem[ip])) * f;
        vmax = acc >>> 17;
      end
      vmin = vmax;
    end else begin
      step = (en - st) / STRIDE_DIV;
      if (step < 1) step = 1;
      vmax = (longint'(left_mem[st]) + longint'(right_mem[st])) >>> 1;
      vmin = vmax;
      for (longint i = st + step; i < en; i += step) begin
        v = (longint'(left_mem[i]) + longint'(right_mem[i])) >>> 1;
        if (v > vmax) vmax = v;
        if (v < vmin) vmin = v;
      end
    end
    r.pmax = vmax[15:0];
    r.pmin = vmin[15:0];
    return r;
  endfunction

  // Lists the store entries that a render of column px reads under the
  // current register values.
  function automatic void column_reads(logic [11:0] px, ref longint addrs[$]);
    longint n, z, s, w, p, vlen, vst, spp, st, en, ip, step;
    addrs.delete();
    n = cfg_frames > STORE_DEPTH ? STORE_DEPTH : cfg_frames;
    z = cfg_zoom < 256 ? 256 : cfg_zoom;
    s = cfg_scroll > 65536 ? 65536 : cfg_scroll;
    w = cfg_width > WIDTH_CAP ? WIDTH_CAP : cfg_width;
    p = px;
    if (n == 0 || w == 0 || p >= w) return;
    vlen = (n * 256) / z;
    vst = (s * (n - vlen)) >> 16;
    spp = (vlen << 16) / w;
    st = vst + ((p * spp) >> 16);
    en = vst + (((p + 1) * spp) >> 16);
    if (en > n) en = n;
    if (st >= en) begin
      ip = st;
      if (n == 1) begin
        addrs.push_back(0);
      end else begin
        if (ip > n - 2) ip = n - 2;
        addrs.push_back(ip);
        addrs.push_back(ip + 1);
      end
    end else begin
      step = (en - st) / STRIDE_DIV;
      if (step < 1) step = 1;
      for (longint i = st; i < en; i += step) addrs.push_back(i);
    end
  endfunction

  // Request driver: a request is taken at an edge with start high and busy
  // low; the bench model is updated at that same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        if (cur_req.mode == wmd_pkg::MODE_LOAD) begin
          left_mem[cur_req.addr]  = cur_req.left;
          right_mem[cur_req.addr] = cur_req.right;
        end else begin
          expected_peaks.push_back(column_peak(cur_req.pixel));
        end
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = pending_reqs.pop_front();
          start <= 1'b1;
          mode <= cur_req.mode;
          frame_address <= cur_req.addr;
          left_sample <= cur_req.left;
          right_sample <= cur_req.right;
          pixel_index <= cur_req.pixel;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every strobe must match the oldest expected column.
  always @(posedge clk) begin
    peak_t e;
    if (!rst && result_valid) begin
      if (expected_peaks.size() == 0) begin
        $display("%0t: unexpected result for pixel %0d", $time, pixel_out);
        errors++;
      end else begin
        e = expected_peaks.pop_front();
        if (pixel_out !== e.pixel) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time, e.pixel, pixel_out);
          errors++;
        end
        if (peak_max !== e.pmax) begin
          $display("%0t: peak_max expected %0d actual %0d", $time, e.pmax, peak_max);
          errors++;
        end
        if (peak_min !== e.pmin) begin
          $display("%0t: peak_min expected %0d actual %0d", $time, e.pmin, peak_min);
          errors++;
        end
        if (empty_flag !== e.empty) begin
          $display("%0t: empty_flag expected %0b actual %0b", $time, e.empty, empty_flag);
          errors++;
        end
      end
    end
  end

  // Register write: setup cycle, then access cycle; the register is written
  // at the edge that ends the access cycle.
  task automatic reg_write(wmd_pkg::reg_idx_t idx, int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= wmd_pkg::PADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      wmd_pkg::REG_FRAME_COUNT: cfg_frames = value & 32'h1FFFF;
      wmd_pkg::REG_ZOOM:        cfg_zoom   = value & 32'hFFFF;
      wmd_pkg::REG_SCROLL:      cfg_scroll = value & 32'h1FFFF;
      wmd_pkg::REG_WIDTH:       cfg_width  = value & 32'h1FFF;
    endcase
  endtask

  // Waits until every request is taken and every result has come back, then
  // lets a render that might still be running finish.
  task automatic drain();
    wait (pending_reqs.size() == 0 && !start && expected_peaks.size() == 0);
    repeat (SETTLE) @(posedge clk);
    wait (!busy);
  endtask

  task automatic apply_setting(int unsigned n, int unsigned z, int unsigned s,
                               int unsigned w);
    drain();
    reg_write(wmd_pkg::REG_FRAME_COUNT, n);
    reg_write(wmd_pkg::REG_ZOOM, z);
    reg_write(wmd_pkg::REG_SCROLL, s);
    reg_write(wmd_pkg::REG_WIDTH, w);
  endtask

  task automatic push_load(logic [15:0] a, logic signed [15:0] l,
                           logic signed [15:0] r);
    req_t q;
    q.mode = wmd_pkg::MODE_LOAD;
    q.addr = a;
    q.left = l;
    q.right = r;
    q.pixel = 12'($urandom);
    written[a] = 1'b1;
    pending_reqs.push_back(q);
  endtask

  // Loads a random pair, a mono one in about a quarter of the cases.
  task automatic push_fill(logic [15:0] a);
    logic signed [15:0] l;
    l = 16'($urandom);
    if ($urandom_range(3) == 0) push_load(a, l, l);
    else push_load(a, l, 16'($urandom));
  endtask

  // Queues a render, preceded by loads of any entry it reads that was never
  // written.
  task automatic push_render(logic [11:0] px);
    req_t q;
    longint addrs[$];
    column_reads(px, addrs);
    foreach (addrs[k]) begin
      if (!written[addrs[k]]) push_fill(16'(addrs[k]));
    end
    q.mode = wmd_pkg::MODE_RENDER;
    q.addr = 16'($urandom);
    q.left = 16'($urandom);
    q.right = 16'($urandom);
    q.pixel = px;
    pending_reqs.push_back(q);
  endtask

  initial begin
    int unsigned n, z, s, w, lim;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The low part of the store is filled up front; some entries hold a
    // mono pair and a few hold full-scale values.
    for (int a = 0; a < 256; a++) push_fill(16'(a));
    push_load(16'd3, 16'sh7FFF, 16'sh7FFF);
    push_load(16'd4, -16'sh8000, -16'sh8000);
    push_load(16'd5, 16'sh7FFF, -16'sh8000);

    // Directed part: empty cases, single frame, interpolation, saturation.
    apply_setting(0, 256, 0, 100);
    push_render(0);
    apply_setting(1000, 256, 0, 0);
    push_render(0);
    apply_setting(1, 256, 0, 4);
    push_render(0);
    push_render(3);
    push_render(4);
    apply_setting(8, 256, 0, 3);
    push_render(0);
    push_render(1);
    push_render(2);
    apply_setting(10, 65535, 32768, 4000);
    push_render(0);
    push_render(1999);
    push_render(3999);
    push_render(12'hFFF);
    apply_setting(131071, 0, 131071, 8191);
    push_render(0);
    push_render(2048);
    push_render(4095);
    apply_setting(65536, 512, 65536, 4096);
    push_render(0);
    push_render(4095);
    apply_setting(300, 512, 100000, 7);
    push_render(6);
    push_render(7);
    apply_setting(65536, 700, 40000, 4096);
    push_render(0);
    push_render(4095);
    apply_setting(2, 256, 0, 4096);
    push_render(0);
    push_render(4095);

    // Random part: a fresh register setting per phase, the sender gaps
    // changing from light to heavy to none across the phases.
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = ph < 4 ? 7 : (ph < 8 ? 87 : 0);
      case ($urandom_range(2))
        0: n = $urandom_range(1, 8);
        1: n = $urandom_range(1, 64);
        default: n = $urandom_range(1, 256);
      endcase
      case ($urandom_range(3))
        0: z = 256;
        1: z = $urandom_range(0, 1023);
        default: z = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(2))
        0: s = 0;
        1: s = 65536;
        default: s = $urandom_range(0, 131071);
      endcase
      case ($urandom_range(7))
        0: w = 0;
        1, 2: w = $urandom_range(1, 16);
        3: w = $urandom_range(4097, 8191);
        default: w = $urandom_range(1, 4096);
      endcase
      apply_setting(n, z, s, w);
      lim = (w > WIDTH_CAP ? WIDTH_CAP : w);
      for (int k = 0; k < 24; k++) begin
        if ($urandom_range(99) < 30) begin
          push_fill(16'($urandom_range(0, 299)));
        end else if (lim > 0 && $urandom_range(99) < 85) begin
          push_render(12'($urandom_range(0, lim - 1)));
        end else begin
          push_render(12'($urandom));
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/wmd_pkg.sv
design/wmd_div.sv
design/wmd_ctrl.sv
design/wmd_dp.sv
design/waveform_minmax_decimator.sv
tb/waveform_minmax_decimator_test.sv
